// ===== design/bsoc_pkg.sv =====
package bsoc_pkg;

    // Field widths of the channels.
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TOUT_W  = 15;
    localparam int POUT_W  = 17;

    // Internal datapath widths, sized from the worst case of every input.
    localparam int DT_W    = RAW_W + 1;       // raw minus reference, signed
    localparam int PRODC_W = 42;              // temperature difference times a coefficient
    localparam int DD_W    = 2 * DT_W;        // square of the temperature difference
    localparam int TEMP_W  = 20;              // first-order temperature
    localparam int T2_W    = 18;              // second-order temperature term
    localparam int TC_W    = 21;              // corrected temperature
    localparam int OFF_W   = 42;              // offset
    localparam int SENS_W  = 41;              // sensitivity
    localparam int SQ_W    = 36;              // squares of the temperature distances
    localparam int CORR_W  = 40;              // offset and sensitivity corrections
    localparam int PPL_W   = RAW_W + 20;      // low partial product
    localparam int PPH_W   = RAW_W + 1 + SENS_W - 20;  // high partial product
    localparam int PROD_W  = PPH_W + 20;      // full raw pressure times sensitivity
    localparam int X_W     = 45;              // scaled product minus offset
    localparam int P_W     = 30;              // pressure before saturation

    // Temperature thresholds and limits in 0.01 C.
    localparam int T_REF_C  = 2000;
    localparam int T_LOW_C  = -1500;
    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;

    // Pressure window and limits in 0.01 mbar.
    localparam int P_VALID_LO = 30000;
    localparam int P_VALID_HI = 125000;
    localparam int P_MAX      = 131071;

    // Pipeline depth and the width of a configuration register index.
    localparam int NUM_STAGES = 8;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_SENS = 3'd0,
        CFG_PRESS_OFF  = 3'd1,
        CFG_SENS_TC    = 3'd2,
        CFG_OFF_TC     = 3'd3,
        CFG_TEMP_REF   = 3'd4,
        CFG_TEMP_TC    = 3'd5
    } t_cfg_index;

    // Input word.
    typedef struct packed {
        logic [RAW_W-1:0] raw_temperature;
        logic [RAW_W-1:0] raw_pressure;
    } t_in_item;

    // Output word.
    typedef struct packed {
        logic signed [TOUT_W-1:0] temperature_centi;
        logic [POUT_W-1:0]        pressure_centi;
        logic                     pressure_valid;
    } t_out_item;

    // Calibration words.
    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity_coeff;
        logic [CAL_W-1:0] pressure_offset_coeff;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_coeff;
    } t_cal;

    // First-order results handed to the second-order unit.
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic [T2_W-1:0]          t2;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_first;

    // Corrected values handed to the pressure unit.
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TC_W-1:0]   temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_comp;

endpackage

// ===== design/bsoc_first_order.sv =====
module bsoc_first_order
    import bsoc_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_in_item   i_item,
    input  t_cal       i_cal,
    output t_first     o_first
);

    // Stage one: temperature difference against the reference.
    logic signed [DT_W-1:0] n_dt;
    logic signed [DT_W-1:0] r_dt;
    logic [RAW_W-1:0]       r_d1_s1;

    assign n_dt = $signed({1'b0, i_item.raw_temperature})
                - $signed({1'b0, i_cal.reference_temperature, 8'd0});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dt    <= n_dt;
            r_d1_s1 <= i_item.raw_pressure;
        end
    end

    // Stage two: the temperature difference times each coefficient and itself.
    logic signed [PRODC_W-1:0] n_prod_t;
    logic signed [PRODC_W-1:0] n_prod_o;
    logic signed [PRODC_W-1:0] n_prod_s;
    logic signed [DD_W-1:0]    n_dd;
    logic signed [PRODC_W-1:0] r_prod_t;
    logic signed [PRODC_W-1:0] r_prod_o;
    logic signed [PRODC_W-1:0] r_prod_s;
    logic signed [DD_W-1:0]    r_dd;
    logic [RAW_W-1:0]          r_d1_s2;

    assign n_prod_t = r_dt * $signed({1'b0, i_cal.temperature_coeff});
    assign n_prod_o = r_dt * $signed({1'b0, i_cal.offset_temp_coeff});
    assign n_prod_s = r_dt * $signed({1'b0, i_cal.sensitivity_temp_coeff});
    assign n_dd     = r_dt * r_dt;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod_t <= n_prod_t;
            r_prod_o <= n_prod_o;
            r_prod_s <= n_prod_s;
            r_dd     <= n_dd;
            r_d1_s2  <= r_d1_s1;
        end
    end

    // Stage three: scale the products and add the reference terms.
    t_first n_first;
    t_first r_first;

    always_comb begin
        n_first.d1   = r_d1_s2;
        n_first.temp = TEMP_W'(T_REF_C) + TEMP_W'(r_prod_t >>> 23);
        n_first.off  = OFF_W'($signed({1'b0, i_cal.pressure_offset_coeff, 16'd0}))
                     + OFF_W'(r_prod_o >>> 7);
        n_first.sens = SENS_W'($signed({1'b0, i_cal.pressure_sensitivity_coeff, 15'd0}))
                     + SENS_W'(r_prod_s >>> 8);
        // The square is never negative, so the floor is a plain bit slice.
        n_first.t2   = r_dd[T2_W+30:31];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_first <= n_first;
        end
    end

    assign o_first = r_first;

endmodule

// ===== design/bsoc_second_order.sv =====
module bsoc_second_order
    import bsoc_pkg::*;
(
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_first     i_first,
    output t_comp      o_comp
);

    // Stage four: distances from the two thresholds and their squares.
    logic signed [TEMP_W-1:0]   w_a;
    logic signed [TEMP_W-1:0]   w_b;
    logic signed [2*TEMP_W-1:0] w_a_sq;
    logic signed [2*TEMP_W-1:0] w_b_sq;
    logic [SQ_W-1:0]            n_a2;
    logic [SQ_W-1:0]            n_b2;
    logic [SQ_W-1:0]            r_a2;
    logic [SQ_W-1:0]            r_b2;
    logic                       r_cold;
    logic                       r_very_cold;
    t_first                     r_first;

    assign w_a    = i_first.temp - TEMP_W'(T_REF_C);
    assign w_b    = i_first.temp - TEMP_W'(T_LOW_C);
    assign w_a_sq = w_a * w_a;
    assign w_b_sq = w_b * w_b;
    assign n_a2   = w_a_sq[SQ_W-1:0];
    assign n_b2   = w_b_sq[SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a2        <= n_a2;
            r_b2        <= n_b2;
            r_cold      <= (i_first.temp < T_REF_C);
            r_very_cold <= (i_first.temp < T_LOW_C);
            r_first     <= i_first;
        end
    end

    // Stage five: build the corrections from shifts and adds and apply them.
    logic [CORR_W-1:0] w_a5;
    logic [CORR_W-1:0] w_b7;
    logic [CORR_W-1:0] w_b11;
    logic [CORR_W-1:0] w_off2;
    logic [CORR_W-1:0] w_sens2;
    logic [T2_W-1:0]   w_t2;
    t_comp             n_comp;
    t_comp             r_comp;

    always_comb begin
        w_a5  = CORR_W'({r_a2, 2'b00}) + CORR_W'(r_a2);
        w_b7  = CORR_W'({r_b2, 3'b000}) - CORR_W'(r_b2);
        w_b11 = CORR_W'({r_b2, 3'b000}) + CORR_W'({r_b2, 1'b0}) + CORR_W'(r_b2);

        w_off2  = '0;
        w_sens2 = '0;
        w_t2    = '0;
        if (r_cold) begin
            w_off2  = (w_a5 >> 1);
            w_sens2 = (w_a5 >> 2);
            w_t2    = r_first.t2;
            if (r_very_cold) begin
                w_off2  = w_off2 + w_b7;
                w_sens2 = w_sens2 + (w_b11 >> 1);
            end
        end

        n_comp.d1   = r_first.d1;
        n_comp.temp = TC_W'(r_first.temp) - $signed({3'b000, w_t2});
        n_comp.off  = r_first.off - $signed({2'b00, w_off2});
        n_comp.sens = r_first.sens - $signed({1'b0, w_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_comp <= n_comp;
        end
    end

    assign o_comp = r_comp;

endmodule

// ===== design/bsoc_pressure.sv =====
module bsoc_pressure
    import bsoc_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_comp      i_comp,
    output t_out_item  o_item
);

    // Stage six: raw pressure times the sensitivity, in two partial products.
    logic [PPL_W-1:0]         n_pp_lo;
    logic signed [PPH_W-1:0]  n_pp_hi;
    logic [PPL_W-1:0]         r_pp_lo;
    logic signed [PPH_W-1:0]  r_pp_hi;
    logic signed [TC_W-1:0]   r_temp_s6;
    logic signed [OFF_W-1:0]  r_off_s6;

    assign n_pp_lo = i_comp.d1 * i_comp.sens[19:0];
    assign n_pp_hi = $signed({1'b0, i_comp.d1}) * $signed(i_comp.sens[SENS_W-1:20]);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pp_lo   <= n_pp_lo;
            r_pp_hi   <= n_pp_hi;
            r_temp_s6 <= i_comp.temp;
            r_off_s6  <= i_comp.off;
        end
    end

    // Stage seven: combine the partial products.
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TC_W-1:0]   r_temp_s7;
    logic signed [OFF_W-1:0]  r_off_s7;

    assign n_prod = $signed({r_pp_hi, 20'd0})
                  + $signed({{(PROD_W-PPL_W){1'b0}}, r_pp_lo});

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod    <= n_prod;
            r_temp_s7 <= r_temp_s6;
            r_off_s7  <= r_off_s6;
        end
    end

    // Stage eight: remove the offset, scale, check the window and saturate.
    logic signed [X_W-1:0] w_x;
    logic signed [P_W-1:0] w_p;
    t_out_item             n_item;
    t_out_item             r_item;

    assign w_x = X_W'((r_prod >>> 21) - r_off_s7);
    assign w_p = P_W'(w_x >>> 15);

    always_comb begin
        n_item.pressure_valid = (w_p > P_VALID_LO) && (w_p < P_VALID_HI);

        if (w_p < 0) begin
            n_item.pressure_centi = '0;
        end else if (w_p > P_MAX) begin
            n_item.pressure_centi = POUT_W'(P_MAX);
        end else begin
            n_item.pressure_centi = w_p[POUT_W-1:0];
        end

        if (r_temp_s7 < TEMP_MIN) begin
            n_item.temperature_centi = TOUT_W'(TEMP_MIN);
        end else if (r_temp_s7 > TEMP_MAX) begin
            n_item.temperature_centi = TOUT_W'(TEMP_MAX);
        end else begin
            n_item.temperature_centi = r_temp_s7[TOUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== design/baro_second_order_compensation.sv =====
// Barometric pressure compensation with second-order temperature correction.
// The input channel takes one word per cycle while o_in_ready is high, each
// holding a raw temperature and a raw pressure conversion. The output channel
// gives one word per input word: temperature in 0.01 C, pressure in 0.01
// mbar, and a flag that the pressure lies inside the plausible window. Six
// calibration words are loaded through the configuration channel, which is
// always ready; they must only be written while no word is in flight.
// The datapath is an eight-stage pipeline, and it accepts one word per cycle
// unless a stalled receiver has backed up every stage.
// The stage count follows from the multiplier chain: coefficient products,
// the squares for the low-temperature terms, and the 24 by 41 bit pressure
// product split into two partial products.
// When the receiver stalls, each stage holds its word only while the stage
// after it is full, so empty stages keep filling and nothing is dropped.
// Reset clears the pipeline valid bits and sets all calibration words to 0.
module baro_second_order_compensation
    import bsoc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CAL_W-1:0]     i_cfg_data
);

    // Calibration word registers.
    t_cal r_cal;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PRESS_SENS: r_cal.pressure_sensitivity_coeff <= i_cfg_data;
                CFG_PRESS_OFF:  r_cal.pressure_offset_coeff      <= i_cfg_data;
                CFG_SENS_TC:    r_cal.sensitivity_temp_coeff     <= i_cfg_data;
                CFG_OFF_TC:     r_cal.offset_temp_coeff          <= i_cfg_data;
                CFG_TEMP_REF:   r_cal.reference_temperature      <= i_cfg_data;
                CFG_TEMP_TC:    r_cal.temperature_coeff          <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;

    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    // Datapath units.
    t_first w_first;
    t_comp  w_comp;

    bsoc_first_order u_first (
        .i_clk   (i_clk),
        .i_en    (w_en[2:0]),
        .i_item  (i_in_data),
        .i_cal   (r_cal),
        .o_first (w_first)
    );

    bsoc_second_order u_second (
        .i_clk   (i_clk),
        .i_en    (w_en[4:3]),
        .i_first (w_first),
        .o_comp  (w_comp)
    );

    bsoc_pressure u_press (
        .i_clk  (i_clk),
        .i_en   (w_en[7:5]),
        .i_comp (w_comp),
        .o_item (o_out_data)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench
    import bsoc_pkg::*;
();

    // Register indexes that decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SHOWN_MISMATCHES = 40;
    localparam int PHASE_WORDS      = 150;
    localparam int BURST_WORDS      = 350;

    localparam logic [RAW_W-1:0] RAW_ALL_ONES = '1;
    localparam logic [CAL_W-1:0] CAL_ALL_ONES = '1;

    // Nominal calibration of a typical part.
    localparam t_cal NOMINAL_CAL = '{
        pressure_sensitivity_coeff: 16'd40127,
        pressure_offset_coeff:      16'd36924,
        sensitivity_temp_coeff:     16'd23317,
        offset_temp_coeff:          16'd23282,
        reference_temperature:      16'd33464,
        temperature_coeff:          16'd28312
    };

    typedef enum int {
        CAL_TYPICAL,
        CAL_RANDOM,
        CAL_ALL_MAX,
        CAL_CORNERS
    } t_cal_style;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CAL_W-1:0]     i_cfg_data = '0;

    // Calibration as seen by the block, and the readings still owed by it.
    t_cal      calibration = '0;
    t_out_item pending_readings[$];
    t_out_item owed;
    int        error_count = 0;
    int        cycle_count = 0;
    bit        gaps_on = 1'b1;
    bit        stalls_on = 1'b1;
    bit        input_parked = 1'b1;
    int        stall_left = 0;

    baro_second_order_compensation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Compensated temperature and pressure for one raw conversion pair.
    function automatic t_out_item compensate_reading(t_in_item w, t_cal c);
        longint d1, dt, temp, off, sens, t2, off2, sens2, a2, b2, p;
        t_out_item r;
        d1 = longint'(w.raw_pressure);
        dt = longint'(w.raw_temperature) - longint'(c.reference_temperature) * 256;
        temp = T_REF_C + ((dt * longint'(c.temperature_coeff)) >>> 23);
        off = longint'(c.pressure_offset_coeff) * 65536
            + ((dt * longint'(c.offset_temp_coeff)) >>> 7);
        sens = longint'(c.pressure_sensitivity_coeff) * 32768
             + ((dt * longint'(c.sensitivity_temp_coeff)) >>> 8);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        // Second-order terms below 20 C, with the extra terms below -15 C.
        if (temp < T_REF_C) begin
            a2 = (temp - T_REF_C) * (temp - T_REF_C);
            t2 = (dt * dt) >>> 31;
            off2 = (5 * a2) >>> 1;
            sens2 = (5 * a2) >>> 2;
            if (temp < T_LOW_C) begin
                b2 = (temp - T_LOW_C) * (temp - T_LOW_C);
                off2 += 7 * b2;
                sens2 += (11 * b2) >>> 1;
            end
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        // The window flag looks at the pressure before saturation.
        r.pressure_valid = (p > P_VALID_LO) && (p < P_VALID_HI);
        if (temp < TEMP_MIN) temp = TEMP_MIN;
        if (temp > TEMP_MAX) temp = TEMP_MAX;
        if (p < 0) p = 0;
        if (p > P_MAX) p = P_MAX;
        r.temperature_centi = temp[TOUT_W-1:0];
        r.pressure_centi = p[POUT_W-1:0];
        return r;
    endfunction

    // Lowest raw pressure whose compensated pressure reaches the target.
    function automatic int find_raw_pressure(int raw_t, int target, t_cal c);
        int lo, hi, mid;
        t_in_item w;
        t_out_item r;
        lo = 0;
        hi = int'(RAW_ALL_ONES);
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            w.raw_temperature = raw_t[RAW_W-1:0];
            w.raw_pressure = mid[RAW_W-1:0];
            r = compensate_reading(w, c);
            if (int'(r.pressure_centi) >= target) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic t_cal random_calibration(t_cal_style style);
        t_cal r;
        for (int k = 0; k < 6; k++) begin
            case (style)
                CAL_TYPICAL: begin
                    r[k*CAL_W +: CAL_W] = NOMINAL_CAL[k*CAL_W +: CAL_W]
                                        + CAL_W'($urandom_range(0, 8191)) - 16'd4096;
                end
                CAL_RANDOM:  r[k*CAL_W +: CAL_W] = CAL_W'($urandom);
                CAL_ALL_MAX: r[k*CAL_W +: CAL_W] = CAL_ALL_ONES;
                default:     r[k*CAL_W +: CAL_W] = $urandom_range(0, 1) ? CAL_ALL_ONES : '0;
            endcase
        end
        return r;
    endfunction

    // Mostly temperatures near the reference point, some anywhere, some at the rails.
    function automatic t_in_item random_word(t_cal c);
        t_in_item w;
        longint t;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            t = longint'(c.reference_temperature) * 256
              + longint'($urandom_range(0, 4194304)) - 2097152;
            if (t < 0) t = 0;
            if (t > longint'(RAW_ALL_ONES)) t = longint'(RAW_ALL_ONES);
            w.raw_temperature = t[RAW_W-1:0];
            w.raw_pressure = RAW_W'($urandom);
        end else if (mode < 9) begin
            w.raw_temperature = RAW_W'($urandom);
            w.raw_pressure = RAW_W'($urandom);
        end else begin
            w.raw_temperature = $urandom_range(0, 1) ? RAW_ALL_ONES : '0;
            w.raw_pressure = $urandom_range(0, 1) ? RAW_ALL_ONES : '0;
        end
        return w;
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < SHOWN_MISMATCHES) $display("mismatch: %s", what);
        error_count++;
    endtask

    // Send one word, with an occasional idle burst in front of it.
    task automatic send_word(t_in_item w);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            if (!input_parked) i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        input_parked = 1'b0;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_pair(int raw_t, int raw_p);
        t_in_item w;
        w.raw_temperature = raw_t[RAW_W-1:0];
        w.raw_pressure = raw_p[RAW_W-1:0];
        send_word(w);
    endtask

    task automatic park_input();
        if (!input_parked) i_in_valid <= 1'b0;
        input_parked = 1'b1;
    endtask

    // Always waits for a clock edge before the first check, so a send may follow directly.
    task automatic wait_for_readings();
        do @(posedge i_clk); while (pending_readings.size() != 0);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CAL_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Calibration is only loaded once the pipeline has drained.
    task automatic load_calibration(t_cal c, bit with_spare);
        park_input();
        wait_for_readings();
        cfg_write(CFG_PRESS_SENS, c.pressure_sensitivity_coeff);
        cfg_write(CFG_PRESS_OFF, c.pressure_offset_coeff);
        cfg_write(CFG_SENS_TC, c.sensitivity_temp_coeff);
        cfg_write(CFG_OFF_TC, c.offset_temp_coeff);
        cfg_write(CFG_TEMP_REF, c.reference_temperature);
        cfg_write(CFG_TEMP_TC, c.temperature_coeff);
        if (with_spare) begin
            cfg_write(CFG_SPARE_LO, CAL_W'($urandom));
            cfg_write(CFG_SPARE_HI, CAL_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // With every word still zero out of reset.
    task automatic test_uncalibrated();
        send_pair(0, 0);
        send_pair(int'(RAW_ALL_ONES), int'(RAW_ALL_ONES));
        send_pair(8569150, 9085466);
    endtask

    // Rails of both fields, the 20 C and -15 C thresholds, and both saturations.
    task automatic test_field_extremes();
        int ref_raw;
        load_calibration(NOMINAL_CAL, 1'b0);
        ref_raw = int'(NOMINAL_CAL.reference_temperature) * 256;
        send_pair(8569150, 9085466);
        send_pair(0, 0);
        send_pair(int'(RAW_ALL_ONES), int'(RAW_ALL_ONES));
        send_pair(0, int'(RAW_ALL_ONES));
        send_pair(int'(RAW_ALL_ONES), 0);
        send_pair(ref_raw, 9085466);
        send_pair(ref_raw - 1, 9085466);
        send_pair(8200000, 9085466);
        send_pair(7400000, 9085466);
    endtask

    // Pressures right on the window edges and on the saturation point.
    task automatic test_pressure_window();
        int raw_lo, raw_hi, raw_top;
        raw_lo = find_raw_pressure(8569150, P_VALID_LO, NOMINAL_CAL);
        raw_hi = find_raw_pressure(8569150, P_VALID_HI, NOMINAL_CAL);
        raw_top = find_raw_pressure(8569150, P_MAX, NOMINAL_CAL);
        send_pair(8569150, raw_lo);
        send_pair(8569150, raw_lo + 1);
        send_pair(8569150, raw_hi - 1);
        send_pair(8569150, raw_hi);
        send_pair(8569150, raw_top - 1);
        send_pair(8569150, raw_top);
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_ignored_registers();
        t_cal c;
        c = random_calibration(CAL_TYPICAL);
        load_calibration(c, 1'b1);
        send_pair(8569150, 9085466);
        send_word(random_word(c));
    endtask

    // Several calibrations, each with a stretch of random words and one drain.
    task automatic test_random_calibrations();
        t_cal_style styles[8];
        t_cal c;
        int pause_at;
        styles = '{CAL_ALL_MAX, CAL_TYPICAL, CAL_RANDOM, CAL_CORNERS,
                   CAL_TYPICAL, CAL_RANDOM, CAL_TYPICAL, CAL_CORNERS};
        foreach (styles[s]) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            c = random_calibration(styles[s]);
            load_calibration(c, 1'b0);
            pause_at = $urandom_range(20, PHASE_WORDS - 20);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i == pause_at) begin
                    park_input();
                    wait_for_readings();
                end
                send_word(random_word(c));
            end
        end
    endtask

    // Full rate on both sides to close the run.
    task automatic test_back_to_back();
        t_cal c;
        c = random_calibration(CAL_TYPICAL);
        load_calibration(c, 1'b0);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        for (int i = 0; i < BURST_WORDS; i++) send_word(random_word(c));
    endtask

    // Receiver stalls in bursts while stalls are on, and is ready otherwise.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Track register writes, predict each accepted word, check each result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRESS_SENS: calibration.pressure_sensitivity_coeff = i_cfg_data;
                    CFG_PRESS_OFF:  calibration.pressure_offset_coeff = i_cfg_data;
                    CFG_SENS_TC:    calibration.sensitivity_temp_coeff = i_cfg_data;
                    CFG_OFF_TC:     calibration.offset_temp_coeff = i_cfg_data;
                    CFG_TEMP_REF:   calibration.reference_temperature = i_cfg_data;
                    CFG_TEMP_TC:    calibration.temperature_coeff = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                pending_readings.push_back(compensate_reading(i_in_data, calibration));
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("result word with no reading pending");
                end else begin
                    owed = pending_readings.pop_front();
                    if (o_out_data.temperature_centi !== owed.temperature_centi) begin
                        report_mismatch($sformatf("temperature_centi got %0d expected %0d",
                            o_out_data.temperature_centi, owed.temperature_centi));
                    end
                    if (o_out_data.pressure_centi !== owed.pressure_centi) begin
                        report_mismatch($sformatf("pressure_centi got %0d expected %0d",
                            o_out_data.pressure_centi, owed.pressure_centi));
                    end
                    if (o_out_data.pressure_valid !== owed.pressure_valid) begin
                        report_mismatch($sformatf("pressure_valid got %b expected %b",
                            o_out_data.pressure_valid, owed.pressure_valid));
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_uncalibrated();
        test_field_extremes();
        test_pressure_window();
        test_ignored_registers();
        test_random_calibrations();
        test_back_to_back();
        park_input();
        wait_for_readings();
        repeat (4 * NUM_STAGES) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            report_mismatch($sformatf("%0d readings never came out", pending_readings.size()));
        end
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
